### hw/rtl/zyz_pkg.sv
// Shared types, constants and the arctangent table for the ZYZ Euler decomposer.
// No dependencies; imported by the CORDIC cell and the top level.
`default_nettype none
package zyz_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int GUARD_BITS      = 8;
  localparam int XW              = 28;  // CORDIC x/y datapath width
  localparam int ZW              = 36;  // Q30 angle width
  localparam int IDXW            = 5;   // stage index width
  localparam int THR_W           = 15;
  localparam int MAGC_W          = 18;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic [19:0]          INVK_Q20    = 20'd636751;

  // One vector moving down a CORDIC row
  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  // Q30 arctangent of 2^-i, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IDXW-1:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      5'd0: r = 36'sd843314857;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;
      5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;
      5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;
      5'd9: r = 36'sd2097149;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    if (i == 5'd31) r = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/zyz_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its output register.
// Depends on zyz_pkg for the vector type and arctangent table.
`default_nettype none
module zyz_cordic_cell (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [zyz_pkg::IDXW-1:0]  stage_idx,
  input  wire zyz_pkg::cordic_vec_t      vec_in,
  output zyz_pkg::cordic_vec_t           vec_out
);
  import zyz_pkg::*;

  cordic_vec_t vec_r, vec_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] dz;

  // Rotate toward the x axis
  always_comb begin
    dx = vec_in.y >>> stage_idx;
    dy = vec_in.x >>> stage_idx;
    dz = atan_q30(stage_idx);
    vec_nxt.zero = vec_in.zero;
    if (!vec_in.y[XW-1]) begin
      vec_nxt.x = vec_in.x + dx;
      vec_nxt.y = vec_in.y - dy;
      vec_nxt.z = vec_in.z + dz;
    end else begin
      vec_nxt.x = vec_in.x - dx;
      vec_nxt.y = vec_in.y + dy;
      vec_nxt.z = vec_in.z - dz;
    end
  end

  // Advance when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) vec_r <= vec_nxt;
  end

  assign vec_out = vec_r;
endmodule
`default_nettype wire

### hw/rtl/zyz_euler_angle_decompose_top.sv
// ZYZ Euler decomposer top level: four entry CORDIC rows, a magnitude row,
// branch logic and output register. Depends on zyz_pkg and zyz_cordic_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries one 2x2 unitary (eight signed
//   Q1.15 parts). Output channel out_valid/out_ready returns theta, beta,
//   alpha and delta in radians with 13 fraction bits, one result per input.
//   The cfg channel writes the 15-bit u11 magnitude threshold; cfg_ready is
//   always high and the value is used by every later transaction.
//   From acceptance to out_valid a transaction passes one prerotation
//   stage, 16 entry CORDIC cells, one compensation stage, 16 magnitude
//   CORDIC cells and the output register. Throughput is one transaction per
//   cycle while the receiver does not stall; every stage advances together.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops; with the output register empty it keeps
//   accepting. Reset clears all valid bits and sets the threshold to 1.
`default_nettype none
module zyz_euler_angle_decompose_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] in_u11_re,
  input  wire logic signed [15:0] in_u11_im,
  input  wire logic signed [15:0] in_u12_re,
  input  wire logic signed [15:0] in_u12_im,
  input  wire logic signed [15:0] in_u21_re,
  input  wire logic signed [15:0] in_u21_im,
  input  wire logic signed [15:0] in_u22_re,
  input  wire logic signed [15:0] in_u22_im,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]        out_theta_angle,
  output logic signed [16:0] out_beta_angle,
  output logic signed [16:0] out_alpha_angle,
  output logic signed [16:0] out_delta_phase,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [zyz_pkg::THR_W-1:0] cfg_data
);
  import zyz_pkg::*;

  localparam int NE     = 4;
  localparam int NVLD   = 2 * CORDIC_STAGES + 2;
  localparam int DLY    = CORDIC_STAGES - 1;
  localparam int RSH    = 30 - ANGLE_FRAC_BITS;

  logic en;
  logic [THR_W-1:0] thr_r;
  logic [NVLD-1:0]  vld_r;
  logic             out_valid_r;

  // Advance whenever the output register is free or being drained
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // Valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NVLD-2:0], in_valid};
      out_valid_r <= vld_r[NVLD-1];
    end
  end

  // Prerotation of the four entries
  logic signed [SAMPLE_WIDTH-1:0] re_in [NE];
  logic signed [SAMPLE_WIDTH-1:0] im_in [NE];
  cordic_vec_t pre_nxt [NE];
  cordic_vec_t pre_r   [NE];

  assign re_in[0] = in_u11_re;  assign im_in[0] = in_u11_im;
  assign re_in[1] = in_u12_re;  assign im_in[1] = in_u12_im;
  assign re_in[2] = in_u21_re;  assign im_in[2] = in_u21_im;
  assign re_in[3] = in_u22_re;  assign im_in[3] = in_u22_im;

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      logic signed [XW-1:0] xs, ys;
      xs = XW'(re_in[e]) <<< GUARD_BITS;
      ys = XW'(im_in[e]) <<< GUARD_BITS;
      pre_nxt[e].zero = (xs == '0) && (ys == '0);
      if (xs[XW-1]) begin
        pre_nxt[e].x = -xs;
        pre_nxt[e].y = -ys;
        pre_nxt[e].z = ys[XW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        pre_nxt[e].x = xs;
        pre_nxt[e].y = ys;
        pre_nxt[e].z = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) pre_r <= pre_nxt;
  end

  // Entry CORDIC rows
  cordic_vec_t ent_v [NE][CORDIC_STAGES+1];

  for (genvar e = 0; e < NE; e++) begin : g_ent
    assign ent_v[e][0] = pre_r[e];
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      zyz_cordic_cell u_cell (
        .clk       (clk),
        .en        (en),
        .stage_idx (IDXW'(k)),
        .vec_in    (ent_v[e][k]),
        .vec_out   (ent_v[e][k+1])
      );
    end
  end

  // Clamp phases, mask zero entries, compensate the u11 magnitude
  logic signed [ZW-1:0] ang_nxt [NE];
  logic signed [ZW-1:0] ang_r   [NE];
  logic signed [XW-1:0] m11_nxt, m12_nxt, m11_r, m12_r;
  logic [MAGC_W-1:0]    m11c_nxt, m11c_r;
  logic [XW+20:0]       prod;

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      logic signed [ZW-1:0] a;
      a = ent_v[e][CORDIC_STAGES].z;
      if (ent_v[e][CORDIC_STAGES].zero)  ang_nxt[e] = '0;
      else if (a > PI_Q30)               ang_nxt[e] = PI_Q30;
      else if (a < -PI_Q30)              ang_nxt[e] = -PI_Q30;
      else                               ang_nxt[e] = a;
    end
    m11_nxt = ent_v[0][CORDIC_STAGES].zero ? '0 : ent_v[0][CORDIC_STAGES].x;
    m12_nxt = ent_v[1][CORDIC_STAGES].zero ? '0 : ent_v[1][CORDIC_STAGES].x;
    prod = (XW+21)'($unsigned(m11_nxt)) * (XW+21)'(INVK_Q20)
         + ((XW+21)'(1) << (19 + GUARD_BITS));
    m11c_nxt = MAGC_W'(prod >> (20 + GUARD_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= ang_nxt;
      m11_r  <= m11_nxt;
      m12_r  <= m12_nxt;
      m11c_r <= m11c_nxt;
    end
  end

  // Branch select and Q30 angle arithmetic
  logic signed [ZW-1:0] alpha_nxt, beta_nxt, delta_nxt;
  logic signed [ZW-1:0] alpha_d [DLY+1];
  logic signed [ZW-1:0] beta_d  [DLY+1];
  logic signed [ZW-1:0] delta_d [DLY+1];

  always_comb begin
    if (m11c_r < MAGC_W'(thr_r)) begin
      alpha_nxt = (ang_r[1] - ang_r[2] + PI_Q30) >>> 1;
      beta_nxt  = -alpha_nxt;
      delta_nxt = (ang_r[1] + ang_r[2] - PI_Q30) >>> 1;
    end else begin
      beta_nxt  = ang_r[0] - ang_r[1];
      alpha_nxt = ang_r[1] - ang_r[3];
      delta_nxt = ang_r[0] - (alpha_nxt >>> 1) - (beta_nxt >>> 1);
    end
  end

  // Delay the angles alongside the magnitude row
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_d[0] <= alpha_nxt;
      beta_d[0]  <= beta_nxt;
      delta_d[0] <= delta_nxt;
      for (int d = 1; d <= DLY; d++) begin
        alpha_d[d] <= alpha_d[d-1];
        beta_d[d]  <= beta_d[d-1];
        delta_d[d] <= delta_d[d-1];
      end
    end
  end

  // Magnitude CORDIC row: atan2(|u12|, |u11|)
  cordic_vec_t mag_v [CORDIC_STAGES+1];

  always_comb begin
    mag_v[0].zero = (m11_r == '0) && (m12_r == '0);
    mag_v[0].x    = m11_r;
    mag_v[0].y    = m12_r;
    mag_v[0].z    = '0;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_mag
    zyz_cordic_cell u_cell (
      .clk       (clk),
      .en        (en),
      .stage_idx (IDXW'(k)),
      .vec_in    (mag_v[k]),
      .vec_out   (mag_v[k+1])
    );
  end

  // Clamp, double and round into the output register
  logic signed [ZW-1:0] th_c, th_rnd, be_rnd, al_rnd, de_rnd;
  logic [14:0]          theta_r;
  logic signed [16:0]   beta_r, alpha_r, delta_r;

  always_comb begin
    if (mag_v[CORDIC_STAGES].zero || mag_v[CORDIC_STAGES].z[ZW-1]) th_c = '0;
    else if (mag_v[CORDIC_STAGES].z > HALF_PI_Q30)                   th_c = HALF_PI_Q30;
    else                                                              th_c = mag_v[CORDIC_STAGES].z;
    th_rnd = ((th_c <<< 1) + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    be_rnd = (beta_d[DLY]  + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    al_rnd = (alpha_d[DLY] + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    de_rnd = (delta_d[DLY] + (ZW'(1) <<< (RSH - 1))) >>> RSH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= th_rnd[14:0];
      beta_r  <= be_rnd[16:0];
      alpha_r <= al_rnd[16:0];
      delta_r <= de_rnd[16:0];
    end
  end

  assign out_theta_angle = theta_r;
  assign out_beta_angle  = beta_r;
  assign out_alpha_angle = alpha_r;
  assign out_delta_phase = delta_r;

endmodule
`default_nettype wire
